// File: rtl/core/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Short forms for the concurrent assertions of the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, stream packing, request kinds and control characters.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Default screen geometry.
   localparam int DEF_COLUMNS   = 80;
   localparam int DEF_ROWS      = 25;
   localparam int DEF_TAB_WIDTH = 4;

   // Field widths.
   localparam int KIND_W       = 2;
   localparam int CHAR_W       = 8;
   localparam int CELL_ADDR_W  = 11;
   localparam int CURSOR_POS_W = 11;
   localparam int CELL_DATA_W  = 16;
   localparam int ATTR_W       = 8;

   // Stream packing, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - CURSOR_POS_W - CELL_DATA_W;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Control characters.
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

endpackage

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell screen with a cursor, written one byte per request.
// ----------------------------------------------------------------------------
// A put request passes through the exec and done states before its response
// is raised, and a read request through the exec, read and done states (a
// read off the screen skips the read state); the block takes no new request
// meanwhile and is ready again in the same cycle as the response is raised.
// A clear, and a put that moves the cursor past the last row and so scrolls
// the screen, walks every cell through the single write port of the screen
// memory in the sweep state before its response is raised. A response still
// waiting does not stop the next request from being taken, but the next
// response then waits until the first is taken. The screen is not cleared
// after reset: its contents are undefined until the first clear request, and
// no request should read or scroll cells before that.
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS   = DEF_COLUMNS,
   parameter int ROWS      = DEF_ROWS,
   parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // char_code [7:0], cell_address [18:8], zero above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind [1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_position [10:0], cell_data [26:11], zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int SCAN_W    = $clog2(CELLS + 1);
   localparam int SRC_W     = $clog2(CELLS + COLUMNS + 1);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int CN_W      = $clog2(COLUMNS + TAB_WIDTH);
   localparam int PH_W      = $clog2(TAB_WIDTH);
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
   localparam int BS_PHASE  = (COLUMNS - 1) % TAB_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type                state_ff;
   kind_type                 kind_ff;
   logic [CHAR_W-1:0]        char_ff;
   logic [CELL_ADDR_W-1:0]   raddr_ff;
   logic [COL_W-1:0]         col_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [PH_W-1:0]          phase_ff;
   logic [ATTR_W-1:0]        attr_ff;
   logic [SCAN_W-1:0]        scan_ff;
   logic [ADDR_W-1:0]        dst_ff;
   logic                     pend_ff;
   logic                     blank_all_ff;
   logic [CELL_DATA_W-1:0]   rd_data_ff;
   logic [CELL_DATA_W-1:0]   cell_ff;
   logic                     rsp_valid_ff;
   logic [CURSOR_POS_W-1:0]  rsp_pos_ff;
   logic [CELL_DATA_W-1:0]   rsp_cell_ff;

   logic [CELL_DATA_W-1:0]   screen_mem [CELLS];

   logic [ADDR_W-1:0]        cur_lin;
   logic [CELL_DATA_W-1:0]   blank_cell;
   logic                     read_in_range;
   logic [SRC_W-1:0]         src;

   // Put decode
   logic [CN_W-1:0]          col_nx;
   logic [PH_W-1:0]          phase_nx;
   logic                     row_step;
   logic                     row_back;
   logic                     put_we;
   logic [ADDR_W-1:0]        put_waddr;
   logic [CELL_DATA_W-1:0]   put_wdata;

   // Memory ports
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [CELL_DATA_W-1:0]   mem_wdata;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_cell_ff, rsp_pos_ff};

   assign cur_lin       = ADDR_W'(row_ff * COLUMNS + col_ff);
   assign blank_cell    = {attr_ff, CHAR_SPACE};
   assign read_in_range = (raddr_ff < CELL_ADDR_W'(CELLS)) || (CELLS > (1 << CELL_ADDR_W));
   assign src           = SRC_W'(scan_ff) + SRC_W'(COLUMNS);

   // The column is kept together with its phase within a tab stop, so a tab
   // needs no remainder logic.
   always_comb begin
      col_nx    = CN_W'(col_ff);
      phase_nx  = phase_ff;
      row_step  = 1'b0;
      row_back  = 1'b0;
      put_we    = 1'b0;
      put_waddr = cur_lin;
      put_wdata = {attr_ff, char_ff};
      priority if (char_ff == CHAR_BS) begin
         if (cur_lin != '0) begin
            put_we    = 1'b1;
            put_waddr = cur_lin - ADDR_W'(1);
            put_wdata = blank_cell;
            if (col_ff == '0) begin
               col_nx   = CN_W'(COLUMNS - 1);
               phase_nx = PH_W'(BS_PHASE);
               row_back = 1'b1;
            end else begin
               col_nx   = CN_W'(col_ff) - CN_W'(1);
               phase_nx = (phase_ff == '0) ? PH_W'(TAB_WIDTH - 1) : phase_ff - PH_W'(1);
            end
         end
      end else if (char_ff == CHAR_TAB) begin
         col_nx   = CN_W'(col_ff) + CN_W'(TAB_WIDTH) - CN_W'(phase_ff);
         phase_nx = '0;
      end else if (char_ff == CHAR_CR) begin
         col_nx   = '0;
         phase_nx = '0;
      end else if (char_ff == CHAR_LF) begin
         col_nx   = '0;
         phase_nx = '0;
         row_step = 1'b1;
      end else if (char_ff >= CHAR_SPACE) begin
         put_we   = 1'b1;
         col_nx   = CN_W'(col_ff) + CN_W'(1);
         phase_nx = (phase_ff == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + PH_W'(1);
      end else begin
         // Remaining control bytes leave the screen and cursor alone.
         put_we = 1'b0;
      end
      if (col_nx >= CN_W'(COLUMNS)) begin
         col_nx   = '0;
         phase_nx = '0;
         row_step = 1'b1;
      end
   end

   // One write port shared by the put path and the sweep; the sweep copies
   // each cell one row up in the cycle after reading it, or blanks it.
   always_comb begin
      mem_we    = pend_ff || (state_ff == ST_EXEC && kind_ff == KIND_PUT && put_we);
      mem_waddr = pend_ff ? dst_ff : put_waddr;
      if (!pend_ff) begin
         mem_wdata = put_wdata;
      end else if (blank_all_ff || dst_ff >= ADDR_W'(LAST_BASE)) begin
         mem_wdata = blank_cell;
      end else begin
         mem_wdata = rd_data_ff;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(raddr_ff);
      if (state_ff == ST_EXEC && kind_ff == KIND_READ && read_in_range) begin
         rd_en = 1'b1;
      end else if (state_ff == ST_SWEEP && !blank_all_ff && src < SRC_W'(CELLS)) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(src);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the done state the response register is handled below.
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= kind_type'(req_tuser);
                  char_ff  <= req_tdata[CHAR_W-1:0];
                  raddr_ff <= req_tdata[CHAR_W +: CELL_ADDR_W];
                  cell_ff  <= '0;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               unique case (kind_ff)
                  KIND_PUT: begin
                     col_ff   <= COL_W'(col_nx);
                     phase_ff <= phase_nx;
                     state_ff <= ST_DONE;
                     if (row_back) begin
                        row_ff <= row_ff - ROW_W'(1);
                     end else if (row_step) begin
                        if (row_ff == ROW_W'(ROWS - 1)) begin
                           scan_ff      <= '0;
                           blank_all_ff <= 1'b0;
                           state_ff     <= ST_SWEEP;
                        end else begin
                           row_ff <= row_ff + ROW_W'(1);
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     col_ff       <= '0;
                     row_ff       <= '0;
                     phase_ff     <= '0;
                     scan_ff      <= '0;
                     blank_all_ff <= 1'b1;
                     state_ff     <= ST_SWEEP;
                  end
                  KIND_READ: begin
                     state_ff <= read_in_range ? ST_READ : ST_DONE;
                  end
                  default: begin
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_READ: begin
               cell_ff  <= rd_data_ff;
               state_ff <= ST_DONE;
            end
            ST_SWEEP: begin
               if (scan_ff != SCAN_W'(CELLS)) begin
                  pend_ff <= 1'b1;
                  dst_ff  <= ADDR_W'(scan_ff);
                  scan_ff <= scan_ff + SCAN_W'(1);
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_ff   <= CURSOR_POS_W'(cur_lin);
                  rsp_cell_ff  <= cell_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the request and response streams.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_macros.svh"

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CELLS = ROWS * COLUMNS;

   // A stalled response keeps its contents.
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // The block works on one request at a time.
   `TCW_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // The reported cursor always lies on the screen.
   `TCW_ASSERT_NOW(a_cursor_range, clock, reset, rsp_tvalid, (rsp_tdata[CURSOR_POS_W-1:0] < CELLS) || (CELLS > (1 << CURSOR_POS_W)), "cursor off screen")

   // Reset leaves no response pending and the block ready.
   `TCW_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_tvalid && req_tready, "bad state after reset")

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS(COLUMNS),
   .ROWS   (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
